[design/assert_macros.svh]
// Assertion macros shared by the checker files.
// Each macro expects clk_i, and ASSERT_CLK also rst_ni, to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property is checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/crc_pkg.sv]
// ----------------------------------------------------------------------------
// Changeover relay controller package
// Shared types and constants for the front end, the request queue and the
// result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc_pkg;

  localparam int unsigned NumHist   = 6;
  localparam int unsigned NumSeg    = 6;
  localparam int unsigned SegCntW   = 3;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;
  localparam int unsigned CfgW      = 16;

  localparam logic [CfgW-1:0] PulseLengthReset = 16'd25;

  localparam int unsigned HistAuto = 0;
  localparam int unsigned HistMan  = 1;
  localparam int unsigned HistG1   = 2;
  localparam int unsigned HistG2   = 3;
  localparam int unsigned HistRem  = 4;
  localparam int unsigned HistAir  = 5;

  localparam logic [3:0] RelayAuto = 4'b0001;
  localparam logic [3:0] RelayMan  = 4'b0010;
  localparam logic [3:0] RelayG1   = 4'b0100;
  localparam logic [3:0] RelayG2   = 4'b1000;
  localparam logic [3:0] RelayIdle = 4'b1111;

  typedef struct packed {
    logic remote;
    logic fault_one;
    logic fault_two;
    logic on_air;
    logic mode;
    logic generator;
  } led_t;

  typedef struct packed {
    logic [NumSeg-1:0][3:0] seg;
    logic [SegCntW-1:0]     count;
    led_t                   leds;
  } desc_t;

endpackage

[design/crc_front.sv]
// ----------------------------------------------------------------------------
// Changeover relay controller front end
// Debounces the sampled pins, tracks remote enable and turns each request
// into a list of relay drive segments plus the LED levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_front #(
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           action_i,
  input  logic [crc_pkg::InDataW-1:0]    pins_i,
  output crc_pkg::desc_t                 desc_o
);
  import crc_pkg::*;

  localparam logic [HISTORY_BITS-1:0] HistPress   = HISTORY_BITS'(1);
  localparam logic [HISTORY_BITS-1:0] HistRelease = {{(HISTORY_BITS-1){1'b1}}, 1'b0};

  logic [NumHist-1:0][HISTORY_BITS-1:0] hist_q, hist_d, hist_shift, hist_sel;
  logic                                 remote_q, remote_d;
  logic                                 air_on, pr_auto, pr_man, pr_g1, pr_g2;
  logic [3:0]                           align_r, gen_sel, base, cum;
  logic [SegCntW-1:0]                   cnt;

  always_comb begin
    for (int i = 0; i < NumHist; i++) begin
      hist_shift[i] = {hist_q[i][HISTORY_BITS-2:0], pins_i[i]};
    end
  end

  assign hist_sel = action_i ? hist_q : hist_shift;
  assign hist_d   = (accept_i && !action_i) ? hist_shift : hist_q;
  assign remote_d = remote_q ^ (accept_i && !action_i && (hist_shift[HistRem] == HistPress));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= '0;
      remote_q <= 1'b0;
    end else begin
      hist_q   <= hist_d;
      remote_q <= remote_d;
    end
  end

  assign air_on  = |hist_sel[HistAir];
  assign align_r = air_on ? RelayG2 : RelayG1;
  assign gen_sel = (hist_shift[HistG2] == '0) ? RelayG1 : RelayG2;
  assign pr_auto = hist_shift[HistAuto] == HistPress;
  assign pr_man  = hist_shift[HistMan] == HistPress;
  assign pr_g1   = hist_shift[HistG1] == HistPress;
  assign pr_g2   = hist_shift[HistG2] == HistPress;

  always_comb begin
    desc_o.seg = {NumSeg{RelayIdle}};
    cnt        = '0;
    base       = RelayIdle;
    cum        = RelayIdle;
    if (action_i) begin
      desc_o.seg[cnt] = RelayIdle & ~align_r;
      cnt             = cnt + 1'b1;
    end else if (!remote_d) begin
      if (hist_shift[HistAir] == HistPress) begin
        desc_o.seg[cnt] = RelayIdle & ~RelayG2;
        cnt             = cnt + 1'b1;
      end else if (hist_shift[HistAir] == HistRelease) begin
        desc_o.seg[cnt] = RelayIdle & ~RelayG1;
        cnt             = cnt + 1'b1;
      end
    end else if (!pins_i[9]) begin
      if (pr_auto) begin
        cum             = cum & ~RelayAuto;
        desc_o.seg[cnt] = cum;
        cnt             = cnt + 1'b1;
      end
      if (pr_g1) begin
        cum             = cum & ~RelayG1;
        desc_o.seg[cnt] = cum;
        cnt             = cnt + 1'b1;
      end
      if (pr_g2) begin
        cum             = cum & ~RelayG2;
        desc_o.seg[cnt] = cum;
        cnt             = cnt + 1'b1;
      end
    end else begin
      if (pr_man) begin
        desc_o.seg[cnt] = RelayIdle & ~align_r;
        cnt             = cnt + 1'b1;
        desc_o.seg[cnt] = RelayIdle & ~RelayMan;
        cnt             = cnt + 1'b1;
        base            = RelayIdle & ~RelayMan;
      end
      if (pr_g1 || pr_g2) begin
        desc_o.seg[cnt] = base & ~align_r;
        cnt             = cnt + 1'b1;
        desc_o.seg[cnt] = RelayIdle & ~RelayMan;
        cnt             = cnt + 1'b1;
        desc_o.seg[cnt] = RelayIdle & ~RelayAuto;
        cnt             = cnt + 1'b1;
        desc_o.seg[cnt] = RelayIdle & ~gen_sel;
        cnt             = cnt + 1'b1;
      end
    end
    desc_o.count          = cnt;
    desc_o.leds.remote    = remote_d;
    desc_o.leds.fault_one = pins_i[6];
    desc_o.leds.fault_two = pins_i[7];
    desc_o.leds.on_air    = air_on;
    desc_o.leds.mode      = ~pins_i[9];
    desc_o.leds.generator = pins_i[8];
  end

endmodule

[design/crc_queue.sv]
// ----------------------------------------------------------------------------
// Changeover relay controller request queue
// Two-entry queue of decoded requests between the front end and the
// result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  crc_pkg::desc_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output crc_pkg::desc_t rdata_o
);
  import crc_pkg::*;

  desc_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

[design/crc_back.sv]
// ----------------------------------------------------------------------------
// Changeover relay controller result sequencer
// Plays out the drive segments of one decoded request, one result per
// cycle while m_axis_tready is high, and closes it with the idle result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  crc_pkg::desc_t                desc_i,
  output logic                          q_pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [crc_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);
  import crc_pkg::*;

  logic [SegCntW-1:0]  idx_q, idx_d;
  logic                valid_q, valid_d, last_q, last_d, load, final_seg;
  logic [3:0]          relay_q, relay_d;
  led_t                leds_q;

  assign load      = q_valid_i && (!valid_q || m_axis_tready);
  assign final_seg = idx_q == desc_i.count;
  assign q_pop_o   = load && final_seg;
  assign relay_d   = final_seg ? RelayIdle : desc_i.seg[idx_q];
  assign last_d    = final_seg;
  assign idx_d     = !load ? idx_q : (final_seg ? '0 : idx_q + 1'b1);
  assign valid_d   = load || (valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      relay_q <= relay_d;
      last_q  <= last_d;
      leds_q  <= desc_i.leds;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {6'd0, leds_q.generator, leds_q.mode, leds_q.on_air,
                          leds_q.fault_two, leds_q.fault_one, leds_q.remote, relay_q};

endmodule

[design/changeover_relay_controller_core.sv]
// ----------------------------------------------------------------------------
// Changeover relay controller core
// Debounced switch handling and relay pulse sequencing for a generator
// changeover unit.
// ----------------------------------------------------------------------------
// Each request is one timer tick with the sampled pins, or a start-up
// alignment. The front end takes a request whenever the two-entry request
// queue has room, so requests may arrive back to back. The sequencer then
// emits one result per cycle while m_axis_tready is high: each of up to six
// drive segments of the request followed by an idle result with tlast set.
// Over time the result output sets the rate. The pulse length register is
// held for the relay timing outside this core and does not change any
// result.
`timescale 1ns / 1ps

module changeover_relay_controller_core #(
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // auto_button, manual_button, gen1_button, gen2_button, remote_button,
  // on_air_pin, fault_one_pin, fault_two_pin, generator_sense,
  // auto_mode_sense, then zero padding
  input  logic [crc_pkg::InDataW-1:0]   s_axis_tdata,
  // action
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // relay_levels[3:0], remote_enable_out, fault_one_led, fault_two_led,
  // on_air_led, mode_led, generator_led, then zero padding
  output logic [crc_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [crc_pkg::CfgW-1:0]      cfg_data_i
);
  import crc_pkg::*;

  logic            full, push, q_valid, q_pop;
  desc_t           front_desc, back_desc;
  logic [CfgW-1:0] pulse_length_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_length_q <= PulseLengthReset;
    end else if (cfg_valid_i) begin
      pulse_length_q <= cfg_data_i;
    end
  end

  crc_front #(
    .HISTORY_BITS(HISTORY_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (push),
    .action_i (s_axis_tuser),
    .pins_i   (s_axis_tdata),
    .desc_o   (front_desc)
  );

  crc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_desc),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (back_desc)
  );

  crc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .desc_i        (back_desc),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[design/crc_checker.sv]
// ----------------------------------------------------------------------------
// Changeover relay controller checker
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [crc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);
  import crc_pkg::*;

  `ASSERT_CLK(a_valid_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid,
              "result dropped while stalled")
  `ASSERT_CLK(a_data_hold, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata),
              "result changed while stalled")
  `ASSERT_CLK(a_seg_drives, (m_axis_tvalid && !m_axis_tlast) |->
              (m_axis_tdata[3:0] != RelayIdle), "drive segment with no relay held")
  `ASSERT_CLK(a_last_idle, (m_axis_tvalid && m_axis_tlast) |->
              (m_axis_tdata[3:0] == RelayIdle), "closing result does not release all relays")

endmodule

bind changeover_relay_controller_core crc_checker u_crc_checker (.*);
